// ----- src/rrr_pkg.sv -----
// rrr_pkg: shared types and constants for the ray reflect/refract block.
// No dependencies.
`timescale 1ns / 1ps
package rrr_pkg;
  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;
  localparam int RATIO_W = 16;
  localparam int RATIO_FRAC = 14;
endpackage

// ----- src/ray_reflect_refract.sv -----
// ray_reflect_refract: fully pipelined reflect / Snell refract of a ray.
// Depends on rrr_pkg.
//
// Usage:
//   Drive in_* and pulse start; a request is taken when start is high and
//   busy is low. busy is tied low: one request may enter every cycle.
//   The result appears on out_* with out_valid high for one cycle.
//   Throughput is one ray per cycle. The depth is set by seven arithmetic
//   stages, the square-root pipeline (one result bit per stage,
//   FRAC_BITS + 2 stages) and the output register.
//   Reset clears the valid bits; requests in flight are dropped.
//   The receiver cannot stall; results must be taken when shown.
//   Negative refract radicands are clamped to zero and flag total_internal.
`timescale 1ns / 1ps
module ray_reflect_refract
  import rrr_pkg::*;
#(
  parameter int COMP_WIDTH = 18,
  parameter int FRAC_BITS  = 15
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_operation,
  input  logic signed [COMP_WIDTH-1:0] in_dir_x,
  input  logic signed [COMP_WIDTH-1:0] in_dir_y,
  input  logic signed [COMP_WIDTH-1:0] in_dir_z,
  input  logic signed [COMP_WIDTH-1:0] in_norm_x,
  input  logic signed [COMP_WIDTH-1:0] in_norm_y,
  input  logic signed [COMP_WIDTH-1:0] in_norm_z,
  input  logic        [RATIO_W-1:0]    in_index_ratio,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_total_internal
);
  localparam int CW = COMP_WIDTH;
  localparam int PW = 2 * CW;        // product width
  localparam int DW = PW + 2;        // dot-product width
  localparam int SW = PW + 2;        // sum of squares width
  localparam int QW = FRAC_BITS + 2 + FRAC_BITS + 1; // radicand << FRAC
  localparam int RB = (QW + 1) / 2;  // sqrt result bits
  localparam int QE = 2 * RB;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [CW-1:0] comp_t;

  function automatic comp_t sat(input logic signed [DW+CW:0] x);
    if (x > $signed({{(DW+2){1'b0}}, MAXV[CW-2:0]})) return MAXV;
    if (x < $signed({{(DW+2){1'b1}}, MINV[CW-2:0]})) return MINV;
    return x[CW-1:0];
  endfunction

  assign busy = 1'b0;

  // stage 1: component products v.n
  logic        v1_r, op1_r;
  comp_t       vx1_r, vy1_r, vz1_r, nx1_r, ny1_r, nz1_r;
  logic [RATIO_W-1:0] eta1_r;
  logic signed [PW-1:0] px1_r, py1_r, pz1_r;
  // stage 2: dot product
  logic        v2_r, op2_r;
  comp_t       vx2_r, vy2_r, vz2_r, nx2_r, ny2_r, nz2_r;
  logic [RATIO_W-1:0] eta2_r;
  logic signed [DW-1:0] d2_r;
  // stage 3: d*n (scaled by 2 for reflect)
  logic        v3_r, op3_r;
  comp_t       vx3_r, vy3_r, vz3_r, nx3_r, ny3_r, nz3_r;
  logic [RATIO_W-1:0] eta3_r;
  logic signed [DW+CW:0] qx3_r, qy3_r, qz3_r;
  // stage 4: t or reflect result
  logic        v4_r, op4_r;
  comp_t       tx4_r, ty4_r, tz4_r, nx4_r, ny4_r, nz4_r;
  logic [RATIO_W-1:0] eta4_r;
  // stage 5: o = eta*t
  logic        v5_r, op5_r;
  comp_t       ox5_r, oy5_r, oz5_r, nx5_r, ny5_r, nz5_r;
  // stage 6: squares
  logic        v6_r, op6_r;
  comp_t       ox6_r, oy6_r, oz6_r, nx6_r, ny6_r, nz6_r;
  logic signed [PW-1:0] sx6_r, sy6_r, sz6_r;
  // stage 7 (radicand) is entry 0 of the square root pipeline,
  // one result bit per stage after it (restoring)
  logic          sv_r   [RB+1];
  logic          stir_r [RB+1];
  logic [QE-1:0] srem_r [RB+1];
  logic [QE-1:0] srad_r [RB+1];
  logic [RB-1:0] sroot_r[RB+1];
  comp_t         so_r   [RB+1][3];
  comp_t         sn_r   [RB+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; sv_r[0] <= 1'b0;
    end else begin
      v1_r <= start; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; sv_r[0] <= v6_r;
    end
  end

  logic signed [DW-1:0] dsum;
  logic signed [DW+CW:0] tx, ty, tz;
  logic signed [CW+RATIO_W+1:0] ex, ey, ez;
  logic signed [SW-1:0] ssum, rad;

  always_comb begin
    dsum = DW'(px1_r >>> FRAC_BITS) + DW'(py1_r >>> FRAC_BITS)
         + DW'(pz1_r >>> FRAC_BITS);
    tx = (DW+CW+1)'(vx3_r) - (qx3_r >>> FRAC_BITS);
    ty = (DW+CW+1)'(vy3_r) - (qy3_r >>> FRAC_BITS);
    tz = (DW+CW+1)'(vz3_r) - (qz3_r >>> FRAC_BITS);
    ex = ($signed({1'b0, eta4_r}) * tx4_r) >>> RATIO_FRAC;
    ey = ($signed({1'b0, eta4_r}) * ty4_r) >>> RATIO_FRAC;
    ez = ($signed({1'b0, eta4_r}) * tz4_r) >>> RATIO_FRAC;
    ssum = SW'(sx6_r >>> FRAC_BITS) + SW'(sy6_r >>> FRAC_BITS)
         + SW'(sz6_r >>> FRAC_BITS);
    rad = (SW'(1) <<< FRAC_BITS) - ssum;
  end

  always_ff @(posedge clk) begin
    op1_r <= in_operation; eta1_r <= in_index_ratio;
    vx1_r <= in_dir_x; vy1_r <= in_dir_y; vz1_r <= in_dir_z;
    nx1_r <= in_norm_x; ny1_r <= in_norm_y; nz1_r <= in_norm_z;
    px1_r <= in_dir_x * in_norm_x;
    py1_r <= in_dir_y * in_norm_y;
    pz1_r <= in_dir_z * in_norm_z;

    op2_r <= op1_r; eta2_r <= eta1_r;
    vx2_r <= vx1_r; vy2_r <= vy1_r; vz2_r <= vz1_r;
    nx2_r <= nx1_r; ny2_r <= ny1_r; nz2_r <= nz1_r;
    d2_r <= dsum;

    op3_r <= op2_r; eta3_r <= eta2_r;
    vx3_r <= vx2_r; vy3_r <= vy2_r; vz3_r <= vz2_r;
    nx3_r <= nx2_r; ny3_r <= ny2_r; nz3_r <= nz2_r;
    // reflect folds the factor 2 in by shifting d
    qx3_r <= (op2_r == OP_REFLECT ? (DW+CW+1)'(d2_r) <<< 1 : (DW+CW+1)'(d2_r)) * nx2_r;
    qy3_r <= (op2_r == OP_REFLECT ? (DW+CW+1)'(d2_r) <<< 1 : (DW+CW+1)'(d2_r)) * ny2_r;
    qz3_r <= (op2_r == OP_REFLECT ? (DW+CW+1)'(d2_r) <<< 1 : (DW+CW+1)'(d2_r)) * nz2_r;

    op4_r <= op3_r; eta4_r <= eta3_r;
    nx4_r <= nx3_r; ny4_r <= ny3_r; nz4_r <= nz3_r;
    tx4_r <= sat(tx); ty4_r <= sat(ty); tz4_r <= sat(tz);

    op5_r <= op4_r;
    nx5_r <= nx4_r; ny5_r <= ny4_r; nz5_r <= nz4_r;
    if (op4_r == OP_REFLECT) begin
      ox5_r <= tx4_r; oy5_r <= ty4_r; oz5_r <= tz4_r;
    end else begin
      ox5_r <= sat((DW+CW+1)'(ex));
      oy5_r <= sat((DW+CW+1)'(ey));
      oz5_r <= sat((DW+CW+1)'(ez));
    end

    op6_r <= op5_r;
    ox6_r <= ox5_r; oy6_r <= oy5_r; oz6_r <= oz5_r;
    nx6_r <= nx5_r; ny6_r <= ny5_r; nz6_r <= nz5_r;
    sx6_r <= ox5_r * ox5_r; sy6_r <= oy5_r * oy5_r; sz6_r <= oz5_r * oz5_r;

    so_r[0][0] <= ox6_r; so_r[0][1] <= oy6_r; so_r[0][2] <= oz6_r;
    sn_r[0][0] <= nx6_r; sn_r[0][1] <= ny6_r; sn_r[0][2] <= nz6_r;
    srem_r[0] <= '0; sroot_r[0] <= '0;
    // reflect skips refraction: zero radicand gives c = 0
    stir_r[0] <= (op6_r == OP_REFRACT) && rad[SW-1];
    if (op6_r == OP_REFLECT || rad[SW-1]) srad_r[0] <= '0;
    else srad_r[0] <= QE'(rad[FRAC_BITS+1:0]) << FRAC_BITS;
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    logic [QE-1:0] rem_w, trial_w;
    always_comb begin
      rem_w   = (srem_r[k] << 2) | QE'(srad_r[k][QE-1 -: 2]);
      trial_w = (QE'(sroot_r[k]) << 2) | QE'(1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else        sv_r[k+1] <= sv_r[k];
      stir_r[k+1] <= stir_r[k];
      srad_r[k+1] <= srad_r[k] << 2;
      so_r[k+1]   <= so_r[k];
      sn_r[k+1]   <= sn_r[k];
      if (rem_w >= trial_w) begin
        srem_r[k+1]  <= rem_w - trial_w;
        sroot_r[k+1] <= {sroot_r[k][RB-2:0], 1'b1};
      end else begin
        srem_r[k+1]  <= rem_w;
        sroot_r[k+1] <= {sroot_r[k][RB-2:0], 1'b0};
      end
    end
  end

  // final stage: out = o - c*n
  logic signed [RB+CW:0] cx, cy, cz;
  always_comb begin
    cx = $signed({1'b0, sroot_r[RB]}) * sn_r[RB][0];
    cy = $signed({1'b0, sroot_r[RB]}) * sn_r[RB][1];
    cz = $signed({1'b0, sroot_r[RB]}) * sn_r[RB][2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= sv_r[RB];
    out_total_internal <= stir_r[RB];
    out_x <= sat((DW+CW+1)'(so_r[RB][0]) - (DW+CW+1)'(cx >>> FRAC_BITS));
    out_y <= sat((DW+CW+1)'(so_r[RB][1]) - (DW+CW+1)'(cy >>> FRAC_BITS));
    out_z <= sat((DW+CW+1)'(so_r[RB][2]) - (DW+CW+1)'(cz >>> FRAC_BITS));
  end
endmodule

// ----- bench/tb_ray_reflect_refract.sv -----
// tb_ray_reflect_refract: self-checking bench for the ray reflect/refract block.
// Depends on rrr_pkg and ray_reflect_refract; predicts each result in place.
`timescale 1ns / 1ps
module tb_ray_reflect_refract
  import rrr_pkg::*;
();

  localparam int CW = 18;
  localparam int FB = 15;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic              op;
    logic signed [CW-1:0] vx, vy, vz, nx, ny, nz;
    logic [RATIO_W-1:0] eta;
    int                gap;
    bit                wait_empty;
  } ray_req_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 tir;
  } ray_res_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, out_total_internal;
  logic in_operation = 0;
  logic signed [CW-1:0] in_dir_x = 0, in_dir_y = 0, in_dir_z = 0;
  logic signed [CW-1:0] in_norm_x = 0, in_norm_y = 0, in_norm_z = 0;
  logic [RATIO_W-1:0] in_index_ratio = 0;
  logic signed [CW-1:0] out_x, out_y, out_z;

  ray_req_t pending_rays[$];
  ray_res_t expected_vecs[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;

  ray_reflect_refract #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) uut (
    .clk, .rst_n, .start, .busy, .in_operation,
    .in_dir_x, .in_dir_y, .in_dir_z, .in_norm_x, .in_norm_y, .in_norm_z,
    .in_index_ratio, .out_valid, .out_x, .out_y, .out_z, .out_total_internal
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic longint flr(longint x, int s);
    return x >>> s;  // arithmetic shift floors
  endfunction

  function automatic longint sat(longint x, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint int_sqrt(longint x);
    longint res, b;
    res = 0;
    b = longint'(1) <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic ray_res_t trace_ray(ray_req_t q);
    longint v[3], n[3], o[3], r[3];
    longint d, s, rad, c, t, e;
    ray_res_t res;
    v[0] = q.vx; v[1] = q.vy; v[2] = q.vz;
    n[0] = q.nx; n[1] = q.ny; n[2] = q.nz;
    e = longint'(q.eta);
    res.tir = 0;
    d = 0;
    for (int i = 0; i < 3; i++) d += flr(v[i] * n[i], FB);
    d = sat(d, 63 - CW);
    if (q.op == OP_REFLECT) begin
      for (int i = 0; i < 3; i++) r[i] = sat(v[i] - flr(2 * d * n[i], FB), CW);
    end else begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        t = sat(v[i] - flr(d * n[i], FB), CW);
        o[i] = sat(flr(e * t, RATIO_FRAC), CW);
        s += flr(o[i] * o[i], FB);
      end
      rad = (longint'(1) <<< FB) - s;
      if (rad < 0) begin
        rad = 0;
        res.tir = 1;
      end
      c = int_sqrt(rad <<< FB);
      for (int i = 0; i < 3; i++) r[i] = sat(o[i] - flr(c * n[i], FB), CW);
    end
    res.x = r[0][CW-1:0];
    res.y = r[1][CW-1:0];
    res.z = r[2][CW-1:0];
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rnd_comp(bit unit_ish);
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      default: begin
        if (unit_ish)
          return CW'($signed($urandom_range(0, 65536)) - 32768);
        return CW'($urandom);
      end
    endcase
  endfunction

  function automatic ray_req_t rnd_ray();
    ray_req_t q;
    bit mild;
    mild = ($urandom_range(0, 3) != 0);
    q.op = 1'($urandom_range(0, 1));
    q.vx = rnd_comp(mild); q.vy = rnd_comp(mild); q.vz = rnd_comp(mild);
    if (mild && $urandom_range(0, 1)) begin
      // axis-aligned unit normal, sign random
      q.nx = '0; q.ny = '0; q.nz = '0;
      case ($urandom_range(0, 2))
        0: q.nx = $urandom_range(0, 1) ? CW'(32768) : CW'(-32768);
        1: q.ny = $urandom_range(0, 1) ? CW'(32768) : CW'(-32768);
        default: q.nz = $urandom_range(0, 1) ? CW'(32768) : CW'(-32768);
      endcase
    end else begin
      q.nx = rnd_comp(mild); q.ny = rnd_comp(mild); q.nz = rnd_comp(mild);
    end
    q.eta = $urandom_range(0, 3) == 0 ? RATIO_W'($urandom) :
            RATIO_W'($urandom_range(8192, 32768));
    q.gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0;
    q.wait_empty = 0;
    return q;
  endfunction

  function automatic ray_req_t mk(logic op, int vx, int vy, int vz,
                                  int nx, int ny, int nz, int eta);
    ray_req_t q;
    q.op = op; q.vx = CW'(vx); q.vy = CW'(vy); q.vz = CW'(vz);
    q.nx = CW'(nx); q.ny = CW'(ny); q.nz = CW'(nz); q.eta = RATIO_W'(eta);
    q.gap = $urandom_range(0, 11);
    q.wait_empty = 0;
    return q;
  endfunction

  initial begin
    ray_req_t q;
    int mx, mn;
    mx = 131071; mn = -131072;
    // reflect: plain, extremes, non-unit normal
    pending_rays.push_back(mk(OP_REFLECT, 23170, -23170, 0, 0, 32768, 0, 0));
    pending_rays.push_back(mk(OP_REFLECT, mx, mx, mx, mx, mx, mx, 65535));
    pending_rays.push_back(mk(OP_REFLECT, mn, mn, mn, mn, mn, mn, 0));
    pending_rays.push_back(mk(OP_REFLECT, mx, mn, mx, mn, mx, mn, 0));
    pending_rays.push_back(mk(OP_REFLECT, 0, 0, 0, 0, 0, 0, 0));
    // refract: normal incidence, oblique, total internal reflection
    pending_rays.push_back(mk(OP_REFRACT, 0, 0, -32768, 0, 0, 32768, 16384));
    pending_rays.push_back(mk(OP_REFRACT, 23170, 0, -23170, 0, 0, 32768, 12000));
    pending_rays.push_back(mk(OP_REFRACT, 30000, 0, -13000, 0, 0, 32768, 30000));
    pending_rays.push_back(mk(OP_REFRACT, mx, mx, mx, 0, 0, 32768, 65535));
    pending_rays.push_back(mk(OP_REFRACT, mn, mn, mn, mn, mn, mn, 65535));
    pending_rays.push_back(mk(OP_REFRACT, mx, mn, mx, mx, mn, mx, 0));
    pending_rays.push_back(mk(OP_REFRACT, 0, 0, 0, 0, 0, 0, 65535));
    pending_rays.push_back(mk(OP_REFRACT, 1000, -2000, 3000, 20000, 20000, 0, 16384));
    q = mk(OP_REFRACT, -1, -1, -1, -1, -1, -1, 1);
    q.wait_empty = 1;
    pending_rays.push_back(q);
    for (int i = 0; i < 600; i++) begin
      q = rnd_ray();
      if (i == 300) q.wait_empty = 1;
      if (i >= 100 && i < 160) q.gap = 0;  // back-to-back stretch
      pending_rays.push_back(q);
    end
  end

  task automatic drive(ray_req_t q);
    start <= 1;
    in_operation <= q.op;
    in_dir_x <= q.vx; in_dir_y <= q.vy; in_dir_z <= q.vz;
    in_norm_x <= q.nx; in_norm_y <= q.ny; in_norm_z <= q.nz;
    in_index_ratio <= q.eta;
  endtask

  // driver
  int gap_left = 0;
  bit gap_armed = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_vecs.push_back(trace_ray(pending_rays.pop_front()));
        gap_armed = 0;
      end
      if (pending_rays.size() == 0) begin
        start <= 0;
        stim_done = 1;
      end else if (start && !busy && pending_rays[0].gap == 0 &&
                   !pending_rays[0].wait_empty) begin
        drive(pending_rays[0]);
      end else if (!(start && busy)) begin
        if (!gap_armed) begin
          gap_left = pending_rays[0].gap;
          gap_armed = 1;
        end
        if (gap_left > 0) begin
          gap_left--;
          start <= 0;
        end else if (pending_rays[0].wait_empty && expected_vecs.size() != 0) begin
          start <= 0;
        end else begin
          drive(pending_rays[0]);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ray_res_t e;
    if (rst_n && out_valid) begin
      if (expected_vecs.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        errors++;
      end else begin
        e = expected_vecs.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %0d got %0d", e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %0d got %0d", e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %0d got %0d", e.z, out_z); errors++;
        end
        if (out_total_internal !== e.tir) begin
          $error("total_internal expected %0d got %0d", e.tir, out_total_internal);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && expected_vecs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_vecs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
